// ----- sv/sbd_pkg.sv -----
// sbd_pkg: shared types and constants of the switch bank debouncer.
// Holds phase and error codes, register reset values and the beat structs.
// No dependencies; used by sbd_step and switch_bank_debouncer_unit.
package sbd_pkg;

	localparam int unsigned SwWidth = 8;
	localparam int unsigned CfgIdxWidth = 1;

	// debouncer phases
	localparam logic [1:0] PH_INIT     = 2'd0;
	localparam logic [1:0] PH_DEBOUNCE = 2'd1;
	localparam logic [1:0] PH_STABLE   = 2'd2;

	// error codes on the result beat
	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_NO_CHANGE = 2'd1;
	localparam logic [1:0] ERR_BOUNCE    = 2'd2;

	// configuration register indexes
	localparam logic [CfgIdxWidth-1:0] REG_STABLE_COUNT = 1'd0;
	localparam logic [CfgIdxWidth-1:0] REG_GUARDED_MASK = 1'd1;

	// configuration reset values
	localparam logic [SwWidth-1:0] STABLE_COUNT_RST = 8'd5;
	localparam logic [SwWidth-1:0] GUARDED_MASK_RST = 8'd12;

	typedef struct packed {
		logic [SwWidth-1:0] sample;
		logic               restart;
		logic [SwWidth-1:0] ack_closed;
		logic [SwWidth-1:0] ack_open;
	} sbd_item_t;

	typedef struct packed {
		logic [SwWidth-1:0] debounced;
		logic [SwWidth-1:0] closed_events;
		logic [SwWidth-1:0] open_events;
		logic [1:0]         error_code;
	} sbd_result_t;

	typedef struct packed {
		logic [1:0]         phase;
		logic [SwWidth-1:0] candidate_byte;
		logic [SwWidth-1:0] accepted_byte;
		logic [SwWidth-1:0] countdown;
		logic [SwWidth-1:0] closed_flags;
		logic [SwWidth-1:0] open_flags;
	} sbd_state_t;

	typedef struct packed {
		logic [SwWidth-1:0] stable_count;
		logic [SwWidth-1:0] guarded_mask;
	} sbd_cfg_t;

endpackage

// ----- sv/sbd_step.sv -----
// sbd_step: next-state and result logic for one debouncer step.
// Purely combinational; depends on sbd_pkg for the state, beat and config structs.
module sbd_step (
	input  sbd_pkg::sbd_item_t   item,
	input  sbd_pkg::sbd_state_t  cur,
	input  sbd_pkg::sbd_cfg_t    cfg,
	output sbd_pkg::sbd_state_t  nxt,
	output sbd_pkg::sbd_result_t res
);
	import sbd_pkg::*;

	logic [SwWidth-1:0] cnt_dec;
	logic [SwWidth-1:0] chg;
	logic [SwWidth-1:0] blocked;
	logic [1:0]         err;
	sbd_state_t         pre;

	assign cnt_dec = cur.countdown - 8'd1;

	always_comb begin
		// apply acks, then restart
		pre = cur;
		pre.closed_flags = cur.closed_flags & ~item.ack_closed;
		pre.open_flags   = cur.open_flags & ~item.ack_open;
		if (item.restart) begin
			pre.candidate_byte = '0;
			pre.accepted_byte  = '0;
			pre.phase          = PH_INIT;
		end

		nxt     = pre;
		err     = ERR_NONE;
		chg     = pre.accepted_byte ^ pre.candidate_byte;
		blocked = cfg.guarded_mask & pre.open_flags;

		// phase logic
		case (pre.phase)
			PH_DEBOUNCE: begin
				if (item.sample == pre.candidate_byte) begin
					nxt.countdown = cnt_dec;
					if (cnt_dec == '0) begin
						nxt.accepted_byte = pre.candidate_byte;
						nxt.phase         = PH_STABLE;
						if (chg != '0) begin
							nxt.closed_flags = pre.closed_flags
								| (chg & pre.candidate_byte & ~blocked);
							nxt.open_flags = pre.open_flags
								| (chg & ~pre.candidate_byte);
						end else begin
							err = ERR_NO_CHANGE;
						end
					end
				end else begin
					if (pre.countdown != cfg.stable_count) begin
						err = ERR_BOUNCE;
					end
					nxt.phase = PH_INIT;
				end
			end
			PH_STABLE: begin
				if (item.sample != pre.accepted_byte) begin
					nxt.phase = PH_INIT;
				end
			end
			default: begin
				// init and the unused code: latch the sample, load the count
				nxt.candidate_byte = item.sample;
				nxt.countdown      = cfg.stable_count;
				nxt.phase          = PH_DEBOUNCE;
			end
		endcase

		res.debounced     = nxt.accepted_byte;
		res.closed_events = nxt.closed_flags;
		res.open_events   = nxt.open_flags;
		res.error_code    = err;
	end

endmodule

// ----- sv/switch_bank_debouncer_unit.sv -----
// switch_bank_debouncer_unit: debouncer for a bank of eight switches.
// Depends on sbd_pkg and sbd_step.
//
// Usage: each input beat (sample, restart, ack_closed, ack_open) is one
// sample tick; every accepted beat yields exactly one result beat
// (debounced, closed_events, open_events, error_code) on the output channel.
// Both channels use valid/ready. The input beat lands in an input register;
// when the result register is free or draining, the step logic updates the
// debouncer state and loads the result register at the same edge.
// Throughput is one beat per cycle unless the output side stalls, set by the
// state update loop. The input register and the result register decouple the two
// sides: while a result waits, one more beat is still taken and held.
// If out_ready stays low, the input register fills and in_ready drops.
// Configuration: cfg_we writes cfg_wdata to register cfg_index
// (0 stable_count, 1 guarded_mask) in the same cycle; write only when idle.
// Reset (arst_n low) clears the phase to init, all bytes, counts and flags,
// empties both registers and restores stable_count 5, guarded_mask 12.
module switch_bank_debouncer_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [sbd_pkg::SwWidth-1:0]       sample,
	input  logic                              restart,
	input  logic [sbd_pkg::SwWidth-1:0]       ack_closed,
	input  logic [sbd_pkg::SwWidth-1:0]       ack_open,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [sbd_pkg::SwWidth-1:0]       debounced,
	output logic [sbd_pkg::SwWidth-1:0]       closed_events,
	output logic [sbd_pkg::SwWidth-1:0]       open_events,
	output logic [1:0]                        error_code,
	input  logic                              cfg_we,
	input  logic [sbd_pkg::CfgIdxWidth-1:0]   cfg_index,
	input  logic [sbd_pkg::SwWidth-1:0]       cfg_wdata
);
	import sbd_pkg::*;

	sbd_cfg_t    cfg_q;
	sbd_state_t  state_q;
	sbd_state_t  state_nxt;
	sbd_item_t   item_s1;
	logic        valid_s1;
	sbd_result_t res_nxt;
	sbd_result_t res_s2;
	logic        valid_s2;
	logic        advance;

	// step when a beat is held and the result register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.stable_count <= STABLE_COUNT_RST;
			cfg_q.guarded_mask <= GUARDED_MASK_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_STABLE_COUNT: cfg_q.stable_count <= cfg_wdata;
				REG_GUARDED_MASK: cfg_q.guarded_mask <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.sample     <= sample;
			item_s1.restart    <= restart;
			item_s1.ack_closed <= ack_closed;
			item_s1.ack_open   <= ack_open;
		end
	end

	sbd_step u_step (
		.item (item_s1),
		.cur  (state_q),
		.cfg  (cfg_q),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// debouncer state: advance once per processed beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_INIT, default: '0};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid     = valid_s2;
	assign debounced     = res_s2.debounced;
	assign closed_events = res_s2.closed_events;
	assign open_events   = res_s2.open_events;
	assign error_code    = res_s2.error_code;

`ifndef ASSERT_OFF
	// a processed beat always shows up as a result next cycle
	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("processed beat produced no result");

	// an empty input register never stalls the sender
	a_empty_takes_beat: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input register empty but not ready");

	// a bounce always drops the debouncer back to init
	a_bounce_to_init: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res_nxt.error_code == ERR_BOUNCE) |=> state_q.phase == PH_INIT)
		else $error("bounce did not return to init");

	// only defined error codes leave the block
	a_err_code_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (error_code == ERR_NONE || error_code == ERR_NO_CHANGE
			|| error_code == ERR_BOUNCE))
		else $error("undefined error code on result");
`endif

endmodule

// ----- dv/switch_bank_debouncer_unit_tb.sv -----
`timescale 1ns / 100ps
// switch_bank_debouncer_unit_tb: self-checking bench for the switch bank debouncer.
// Predicts each result beat with a local debouncer model and checks it field by field.
// Depends on sbd_pkg and switch_bank_debouncer_unit.
module switch_bank_debouncer_unit_tb;
	import sbd_pkg::*;

	localparam int unsigned CycleLimit = 400000;

	typedef struct {
		sbd_item_t beat;
		bit        drain_first;
	} pending_beat_t;

	logic               clk           = 1'b0;
	logic               arst_n        = 1'b0;
	logic               in_valid      = 1'b0;
	logic               in_ready;
	logic [SwWidth-1:0] sample        = '0;
	logic               restart       = 1'b0;
	logic [SwWidth-1:0] ack_closed    = '0;
	logic [SwWidth-1:0] ack_open      = '0;
	logic               out_valid;
	logic               out_ready     = 1'b0;
	logic [SwWidth-1:0] debounced;
	logic [SwWidth-1:0] closed_events;
	logic [SwWidth-1:0] open_events;
	logic [1:0]         error_code;
	logic               cfg_we        = 1'b0;
	logic [CfgIdxWidth-1:0] cfg_index = '0;
	logic [SwWidth-1:0] cfg_wdata     = '0;

	// local copy of the debouncer state and its registers
	logic [1:0]         deb_phase  = PH_INIT;
	logic [SwWidth-1:0] cand_byte  = '0;
	logic [SwWidth-1:0] acc_byte   = '0;
	logic [SwWidth-1:0] count_left = '0;
	logic [SwWidth-1:0] closed_q   = '0;
	logic [SwWidth-1:0] open_q     = '0;
	logic [SwWidth-1:0] stable_cfg = STABLE_COUNT_RST;
	logic [SwWidth-1:0] guard_cfg  = GUARDED_MASK_RST;

	pending_beat_t pending_beats[$];
	sbd_result_t   expected_results[$];
	sbd_item_t     drv_beat;
	int unsigned   send_gap    = 0;
	int unsigned   recv_stall  = 0;
	bit            send_calm   = 1'b0;
	bit            recv_calm   = 1'b0;
	int unsigned   fail_count  = 0;
	int unsigned   cycle_count = 0;

	switch_bank_debouncer_unit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.sample        (sample),
		.restart       (restart),
		.ack_closed    (ack_closed),
		.ack_open      (ack_open),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.debounced     (debounced),
		.closed_events (closed_events),
		.open_events   (open_events),
		.error_code    (error_code),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// advance the local debouncer by one sample tick and return the result beat
	function automatic sbd_result_t predict_switch_step(sbd_item_t b);
		sbd_result_t        r;
		logic [SwWidth-1:0] changed;
		logic [SwWidth-1:0] blocked;
		r.error_code = ERR_NONE;
		closed_q = closed_q & ~b.ack_closed;
		open_q   = open_q & ~b.ack_open;
		if (b.restart) begin
			cand_byte = '0;
			acc_byte  = '0;
			deb_phase = PH_INIT;
		end
		case (deb_phase)
			PH_DEBOUNCE: begin
				if (b.sample == cand_byte) begin
					count_left = count_left - 8'd1;
					if (count_left == '0) begin
						changed   = acc_byte ^ cand_byte;
						acc_byte  = cand_byte;
						deb_phase = PH_STABLE;
						if (changed != '0) begin
							blocked  = guard_cfg & open_q;
							closed_q = closed_q | (changed & cand_byte & ~blocked);
							open_q   = open_q | (changed & ~cand_byte);
						end else begin
							r.error_code = ERR_NO_CHANGE;
						end
					end
				end else begin
					if (count_left != stable_cfg)
						r.error_code = ERR_BOUNCE;
					deb_phase = PH_INIT;
				end
			end
			PH_STABLE: begin
				if (b.sample != acc_byte)
					deb_phase = PH_INIT;
			end
			default: begin
				cand_byte  = b.sample;
				count_left = stable_cfg;
				deb_phase  = PH_DEBOUNCE;
			end
		endcase
		r.debounced     = acc_byte;
		r.closed_events = closed_q;
		r.open_events   = open_q;
		return r;
	endfunction

	// idle length: mostly none, some short, a few long
	function automatic int unsigned pick_gap(bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic logic [SwWidth-1:0] pick_ack();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return '0;
		if (r < 85)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	task automatic add_beat(input logic [SwWidth-1:0] s, input logic rst,
			input logic [SwWidth-1:0] ac, input logic [SwWidth-1:0] ao, input bit drain);
		pending_beat_t p;
		p.beat.sample     = s;
		p.beat.restart    = rst;
		p.beat.ack_closed = ac;
		p.beat.ack_open   = ao;
		p.drain_first     = drain;
		pending_beats.push_back(p);
	endtask

	task automatic set_register(input logic [CfgIdxWidth-1:0] idx,
			input logic [SwWidth-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		if (idx == REG_STABLE_COUNT)
			stable_cfg = val;
		else
			guard_cfg = val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
	endtask

	// mostly runs of equal samples sized around the stable count, plus noise and restarts
	task automatic add_random_beats(input int unsigned n);
		int unsigned        need;
		int unsigned        run;
		int unsigned        k;
		int unsigned        added;
		int unsigned        r;
		logic [SwWidth-1:0] v;
		logic [SwWidth-1:0] last_v;
		need   = (stable_cfg == '0) ? 256 : stable_cfg;
		added  = 0;
		last_v = 8'($urandom);
		while (added < n) begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				r = $urandom_range(0, 99);
				if (r < 40)
					v = 8'($urandom);
				else if (r < 85)
					v = last_v ^ (8'd1 << $urandom_range(0, 7));
				else
					v = last_v;
				r = $urandom_range(0, 99);
				if (r < 70)
					run = need + 1;
				else if (r < 85)
					run = $urandom_range(1, need);
				else
					run = need + 1 + $urandom_range(1, 4);
				// stay within the beat budget of this phase
				if (run > n - added)
					run = n - added;
				for (k = 0; k < run; k++) begin
					add_beat(v, 1'b0, pick_ack(), pick_ack(),
						added == n / 2 || $urandom_range(0, 99) == 0);
					added++;
				end
				last_v = v;
			end else if (r < 94) begin
				run = $urandom_range(1, 4);
				if (run > n - added)
					run = n - added;
				for (k = 0; k < run; k++) begin
					add_beat(8'($urandom), 1'b0, pick_ack(), pick_ack(), 1'b0);
					added++;
				end
			end else begin
				add_beat(8'($urandom), 1'b1, pick_ack(), pick_ack(), 1'b0);
				added++;
			end
		end
	endtask

	task automatic run_phase(input logic [SwWidth-1:0] stable, input logic [SwWidth-1:0] guard,
			input int unsigned n);
		set_register(REG_STABLE_COUNT, stable);
		set_register(REG_GUARDED_MASK, guard);
		add_random_beats(n);
		wait_drained();
	endtask

	// drive input beats from the pending queue with random gaps
	always @(posedge clk) begin : drive_beats
		pending_beat_t nxt;
		bit            next_valid;
		if (arst_n) begin
			next_valid = in_valid;
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_switch_step(drv_beat));
				next_valid = 1'b0;
				send_gap   = pick_gap(send_calm);
				if ($urandom_range(0, 39) == 0)
					send_calm = !send_calm;
			end
			if (!next_valid) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_beats.size() != 0 &&
						(!pending_beats[0].drain_first || expected_results.size() == 0)) begin
					nxt        = pending_beats.pop_front();
					drv_beat   = nxt.beat;
					next_valid = 1'b1;
				end
			end
			in_valid   <= next_valid;
			sample     <= drv_beat.sample;
			restart    <= drv_beat.restart;
			ack_closed <= drv_beat.ack_closed;
			ack_open   <= drv_beat.ack_open;
		end
	end

	// check result beats against the oldest prediction, stall at random
	always @(posedge clk) begin : check_results
		sbd_result_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result beat arrived with no prediction pending");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (debounced !== want.debounced) begin
						$error("debounced: expected %02h, got %02h", want.debounced, debounced);
						fail_count++;
					end
					if (closed_events !== want.closed_events) begin
						$error("closed_events: expected %02h, got %02h",
							want.closed_events, closed_events);
						fail_count++;
					end
					if (open_events !== want.open_events) begin
						$error("open_events: expected %02h, got %02h",
							want.open_events, open_events);
						fail_count++;
					end
					if (error_code !== want.error_code) begin
						$error("error_code: expected %0d, got %0d", want.error_code, error_code);
						fail_count++;
					end
				end
				recv_stall = pick_gap(recv_calm);
				if ($urandom_range(0, 39) == 0)
					recv_calm = !recv_calm;
			end else if (!out_valid && !recv_calm && recv_stall == 0 &&
					$urandom_range(0, 19) == 0) begin
				recv_stall = $urandom_range(1, 4);
			end
			if (recv_stall > 0) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// hard stop if the run hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: field extremes, guarded close, bounce, no-change and restart
		set_register(REG_STABLE_COUNT, 8'd2);
		set_register(REG_GUARDED_MASK, 8'd12);
		repeat (3) add_beat(8'hFF, 1'b0, 8'h00, 8'h00, 1'b0);
		repeat (4) add_beat(8'h00, 1'b0, 8'h00, 8'h00, 1'b0);
		add_beat(8'h0C, 1'b0, 8'hFF, 8'h00, 1'b0);
		repeat (3) add_beat(8'h0C, 1'b0, 8'h00, 8'h00, 1'b0);
		repeat (3) add_beat(8'h5A, 1'b0, 8'h00, 8'h00, 1'b0);
		repeat (2) add_beat(8'hA5, 1'b0, 8'h00, 8'h00, 1'b0);
		add_beat(8'h3C, 1'b0, 8'h00, 8'h00, 1'b0);
		repeat (3) add_beat(8'h0C, 1'b0, 8'h00, 8'h00, 1'b0);
		add_beat(8'hFF, 1'b1, 8'hFF, 8'hFF, 1'b0);
		repeat (2) add_beat(8'hFF, 1'b0, 8'h00, 8'h00, 1'b0);
		add_beat(8'h00, 1'b1, 8'h00, 8'h00, 1'b1);
		wait_drained();

		// random runs across register settings, extremes included
		run_phase(8'd1, 8'd0, 70);
		run_phase(8'd3, 8'($urandom), 60);
		run_phase(8'd255, 8'hFF, 30);
		run_phase(8'd0, 8'd12, 280);
		run_phase(8'd4, 8'hA5, 60);
		run_phase(8'd1, 8'hFF, 30);

		wait_drained();
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
sv/sbd_pkg.sv
sv/sbd_step.sv
sv/switch_bank_debouncer_unit.sv
dv/switch_bank_debouncer_unit_tb.sv
